>>> design/erov_pkg.sv
// Shared constants, codes and types of the envelope ramp oscillator voice.
// Used by the serial divider and the top level.
package erov_pkg;

	localparam int SegDepth   = 8;
	localparam int PhaseBits  = 24;
	localparam int SineDepth  = 1024;
	localparam int SampleBits = 24;

	// serial divider geometry: |(end - start) * elapsed| over a duration
	localparam int DivNumW = 45;
	localparam int DivDenW = 20;

	localparam logic [15:0] AmpMax  = 16'hFFFF;
	localparam logic [23:0] FreqMax = 24'hFFFFFF;

	// quarter-wave odd polynomial, Q30
	localparam logic [31:0] CoefA1 = 32'd1686629713;
	localparam logic [31:0] CoefA3 = 32'd693598343;
	localparam logic [31:0] CoefA5 = 32'd85569637;
	localparam logic [31:0] CoefA7 = 32'd5026994;
	localparam logic [31:0] CoefA9 = 32'd172272;

	localparam logic [15:0] LfsrSeed = 16'hACE1;
	localparam logic [15:0] LfsrTaps = 16'hB400;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOADA = 2'd1;
	localparam logic [1:0] OP_LOADF = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	localparam logic [1:0] WAVE_SINE  = 2'd0;
	localparam logic [1:0] WAVE_SAW   = 2'd1;
	localparam logic [1:0] WAVE_NOISE = 2'd2;
	// silent: envelopes run, wave value is zero
	localparam logic [1:0] WAVE_MUTE  = 2'd3;

	typedef struct packed {
		logic               done;
		logic [DivNumW-1:0] quot;
	} div_rsp_t;

	// Horner coefficient taken at sine steps 2 to 5
	function automatic logic [31:0] sine_coef(input logic [2:0] step);
		logic [31:0] c;
		case (step)
			3'd2:    c = CoefA7;
			3'd3:    c = CoefA5;
			3'd4:    c = CoefA3;
			default: c = CoefA1;
		endcase
		return c;
	endfunction

endpackage

>>> design/erov_in_if.sv
// Input channel of the voice: valid/ready plus one command word.
// Depends on nothing.
interface erov_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [2:0]         seg_index;
	logic [23:0]        seg_start;
	logic [23:0]        seg_end;
	logic [19:0]        seg_duration;
	logic [3:0]         amp_count;
	logic [3:0]         freq_count;
	logic [1:0]         waveform;
	logic signed [23:0] mix_in;

	modport source(output valid, opcode, seg_index, seg_start, seg_end, seg_duration,
		amp_count, freq_count, waveform, mix_in, input ready);
	modport sink(input valid, opcode, seg_index, seg_start, seg_end, seg_duration,
		amp_count, freq_count, waveform, mix_in, output ready);
endinterface

>>> design/erov_out_if.sv
// Output channel of the voice: valid/ready plus one result word.
// Depends on nothing.
interface erov_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_out;
	logic               voice_active;
	logic               voice_finished;

	modport source(output valid, sample_out, voice_active, voice_finished, input ready);
	modport sink(input valid, sample_out, voice_active, voice_finished, output ready);
endinterface

>>> design/erov_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on erov_pkg.
module erov_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [erov_pkg::DivNumW-1:0] num,
	input  logic [erov_pkg::DivDenW-1:0] den,
	output erov_pkg::div_rsp_t           rsp
);
	localparam int NW = erov_pkg::DivNumW;
	localparam int DW = erov_pkg::DivDenW;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quot_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q[DW-1:0], quot_q[NW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			den_q  <= den;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quot_q <= {quot_q[NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

>>> design/envelope_ramp_oscillator_voice.sv
// One oscillator voice with piecewise linear amplitude and pitch envelopes.
// Depends on erov_pkg, erov_in_if, erov_out_if and erov_div.
//
// Load and start words, and ticks while the voice is silent, finish in one
// cycle and their result is registered on the next. A tick of a playing voice
// runs through one shared 33x33 multiplier and a serial divider: each ramping
// envelope is interpolated by a multiply and then a divide in which the divider
// forms one quotient bit per cycle, and a sine waveform adds 8 sine steps for
// the polynomial and its rounding; a held segment skips the divide, other
// waveforms skip the 8 sine steps. One word is in flight at a time; input ready
// is low until the result has been taken. Segment tables are undefined until
// loaded.
module envelope_ramp_oscillator_voice #(
	parameter int SEGMENT_DEPTH    = erov_pkg::SegDepth,
	parameter int PHASE_BITS       = erov_pkg::PhaseBits,
	parameter int SINE_TABLE_DEPTH = erov_pkg::SineDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	erov_in_if.sink    in_ch,
	erov_out_if.source out_ch
);
	localparam int IDXW = $clog2(SEGMENT_DEPTH);
	localparam int SEGW = $clog2(SEGMENT_DEPTH + 1);
	localparam int LD   = $clog2(SINE_TABLE_DEPTH);
	localparam int SUMW = ((PHASE_BITS > 24) ? PHASE_BITS : 24) + 1;
	localparam int VSH  = 33 - erov_pkg::SampleBits;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_AMUL  = 4'd2;
	localparam logic [3:0] ST_ADIV  = 4'd3;
	localparam logic [3:0] ST_AWAIT = 4'd4;
	localparam logic [3:0] ST_FMUL  = 4'd5;
	localparam logic [3:0] ST_FDIV  = 4'd6;
	localparam logic [3:0] ST_FWAIT = 4'd7;
	localparam logic [3:0] ST_SINE  = 4'd8;
	localparam logic [3:0] ST_VMUL  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	// segment tables
	logic [15:0] amp_start_mem [SEGMENT_DEPTH];
	logic [15:0] amp_end_mem   [SEGMENT_DEPTH];
	logic [19:0] amp_dur_mem   [SEGMENT_DEPTH];
	logic [23:0] freq_start_mem[SEGMENT_DEPTH];
	logic [23:0] freq_end_mem  [SEGMENT_DEPTH];
	logic [19:0] freq_dur_mem  [SEGMENT_DEPTH];

	logic [3:0]            state_q;
	logic                  playing_q;
	logic [SEGW-1:0]       amp_seg_q, freq_seg_q, amp_used_q, freq_used_q;
	logic [19:0]           amp_el_q, freq_el_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [1:0]            wave_sel_q;
	logic [15:0]           lfsr_q;
	logic [2:0]            sin_step_q;

	logic                  out_valid_q;
	logic signed [23:0]    out_sample_q;
	logic                  out_active_q, out_fin_q;

	logic [15:0]           a_start_q, a_end_q, a_val_q;
	logic [19:0]           a_dur_q, f_dur_q;
	logic [23:0]           f_start_q, f_end_q, f_val_q;
	logic signed [23:0]    mix_q;
	logic                  neg_q;
	logic [31:0]           x2_q;
	logic signed [15:0]    wave_q;
	logic signed [65:0]    prod_q;

	logic signed [32:0]    mul_a, mul_b;
	logic                  accept;
	logic                  wr_ok;
	logic [IDXW-1:0]       wr_addr;

	assign accept  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign wr_ok   = int'(in_ch.seg_index) < SEGMENT_DEPTH;
	assign wr_addr = IDXW'(in_ch.seg_index);

	// table writes and the per-tick registered read
	always_ff @(posedge clk) begin
		if (accept && wr_ok && in_ch.opcode == erov_pkg::OP_LOADA) begin
			amp_start_mem[wr_addr] <= in_ch.seg_start[15:0];
			amp_end_mem[wr_addr]   <= in_ch.seg_end[15:0];
			amp_dur_mem[wr_addr]   <= in_ch.seg_duration;
		end
		if (accept && wr_ok && in_ch.opcode == erov_pkg::OP_LOADF) begin
			freq_start_mem[wr_addr] <= in_ch.seg_start;
			freq_end_mem[wr_addr]   <= in_ch.seg_end;
			freq_dur_mem[wr_addr]   <= in_ch.seg_duration;
		end
		if (state_q == ST_READ) begin
			a_start_q <= amp_start_mem[amp_seg_q[IDXW-1:0]];
			a_end_q   <= amp_end_mem[amp_seg_q[IDXW-1:0]];
			a_dur_q   <= amp_dur_mem[amp_seg_q[IDXW-1:0]];
			f_start_q <= freq_start_mem[freq_seg_q[IDXW-1:0]];
			f_end_q   <= freq_end_mem[freq_seg_q[IDXW-1:0]];
			f_dur_q   <= freq_dur_mem[freq_seg_q[IDXW-1:0]];
		end
	end

	// sine argument from the phase
	logic [LD-1:0] sin_k;
	logic [31:0]   sin_u;
	logic [30:0]   x_c;
	assign sin_k = phase_q[PHASE_BITS-1 -: LD];
	assign sin_u = {sin_k, {(32 - LD){1'b0}}};
	assign x_c   = sin_u[30] ? (31'h40000000 - {1'b0, sin_u[29:0]}) : {1'b0, sin_u[29:0]};

	logic signed [16:0] a_diff;
	logic signed [24:0] f_diff;
	logic [31:0]        horner;
	logic signed [15:0] wave_c;
	assign a_diff = $signed({1'b0, a_end_q}) - $signed({1'b0, a_start_q});
	assign f_diff = $signed({1'b0, f_end_q}) - $signed({1'b0, f_start_q});
	assign horner = erov_pkg::sine_coef(sin_step_q) - prod_q[61:30];

	always_comb begin
		case (wave_sel_q)
			erov_pkg::WAVE_SINE:  wave_c = wave_q;
			erov_pkg::WAVE_SAW:   wave_c = $signed(phase_q[PHASE_BITS-1 -: 16]);
			erov_pkg::WAVE_NOISE: wave_c = $signed({1'b0, lfsr_q[15:1]});
			default:              wave_c = '0;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_AMUL: begin
				mul_a = 33'(a_diff);
				mul_b = $signed({13'd0, amp_el_q});
			end
			ST_FMUL: begin
				mul_a = 33'(f_diff);
				mul_b = $signed({13'd0, freq_el_q});
			end
			ST_SINE: begin
				case (sin_step_q)
					3'd0: begin
						mul_a = $signed({2'b0, x_c});
						mul_b = $signed({2'b0, x_c});
					end
					3'd1: begin
						mul_a = $signed({1'b0, prod_q[61:30]});
						mul_b = $signed({1'b0, erov_pkg::CoefA9});
					end
					3'd2, 3'd3, 3'd4: begin
						mul_a = $signed({1'b0, x2_q});
						mul_b = $signed({1'b0, horner});
					end
					3'd5: begin
						mul_a = $signed({2'b0, x_c});
						mul_b = $signed({1'b0, horner});
					end
					3'd6: begin
						mul_a = $signed({1'b0, prod_q[61:30]});
						mul_b = 33'sd32767;
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_VMUL: begin
				mul_a = 33'(wave_c);
				mul_b = $signed({17'd0, a_val_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider hookup: magnitude of the registered product
	logic signed [65:0]   prod_abs;
	erov_pkg::div_rsp_t   div_rsp;
	logic                 div_start;
	logic [19:0]          div_den;
	assign prod_abs  = prod_q[65] ? -prod_q : prod_q;
	assign div_start = (state_q == ST_ADIV) || (state_q == ST_FDIV);
	assign div_den   = (state_q == ST_ADIV) ? a_dur_q : f_dur_q;

	erov_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_abs[erov_pkg::DivNumW-1:0]),
		.den    (div_den),
		.rsp    (div_rsp)
	);

	// start + quotient, clamped to the envelope range
	logic signed [47:0] q_signed, ip_sum;
	logic [23:0]        ip_base, ip_max, ip_val;
	assign q_signed = neg_q ? -$signed({3'b0, div_rsp.quot}) : $signed({3'b0, div_rsp.quot});
	assign ip_base  = (state_q == ST_AWAIT) ? {8'd0, a_start_q} : f_start_q;
	assign ip_max   = (state_q == ST_AWAIT) ? {8'd0, erov_pkg::AmpMax} : erov_pkg::FreqMax;
	assign ip_sum   = $signed({24'd0, ip_base}) + q_signed;
	always_comb begin
		if (ip_sum < 0)
			ip_val = '0;
		else if (ip_sum > $signed({24'd0, ip_max}))
			ip_val = ip_max;
		else
			ip_val = ip_sum[23:0];
	end

	// final sine rounding
	logic [32:0] w_raw;
	logic [15:0] w_cap;
	assign w_raw = 33'((prod_q[62:0] + 63'(64'd1 << 29)) >> 30);
	assign w_cap = (w_raw > 33'd32767) ? 16'd32767 : w_raw[15:0];

	// voice sample and saturating mix
	logic signed [65:0] mix_sum;
	logic signed [23:0] mix_sat;
	assign mix_sum = 66'(mix_q) + (prod_q >>> VSH);
	always_comb begin
		if (mix_sum > 66'sd8388607)
			mix_sat = 24'sh7FFFFF;
		else if (mix_sum < -66'sd8388608)
			mix_sat = 24'sh800000;
		else
			mix_sat = mix_sum[23:0];
	end

	// envelope stepping at the end of a tick
	logic [19:0]   a_el_inc, f_el_inc;
	logic [SEGW:0] a_seg_inc, f_seg_inc;
	logic          a_done, f_done, a_over, f_over;
	logic [SUMW-1:0] phase_sum;
	assign a_el_inc  = amp_el_q + 20'd1;
	assign f_el_inc  = freq_el_q + 20'd1;
	assign a_seg_inc = {1'b0, amp_seg_q} + 1'b1;
	assign f_seg_inc = {1'b0, freq_seg_q} + 1'b1;
	assign a_done    = (a_dur_q != '0) && (a_el_inc >= a_dur_q);
	assign f_done    = (f_dur_q != '0) && (f_el_inc >= f_dur_q);
	assign a_over    = a_done && (a_seg_inc >= {1'b0, amp_used_q});
	assign f_over    = f_done && (f_seg_inc >= {1'b0, freq_used_q});
	assign phase_sum = SUMW'(phase_q) + SUMW'(f_val_q);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept)
			mix_q <= in_ch.mix_in;
		if (state_q == ST_AMUL && a_dur_q == '0)
			a_val_q <= a_start_q;
		if (state_q == ST_FMUL && f_dur_q == '0)
			f_val_q <= f_start_q;
		if (div_start)
			neg_q <= prod_q[65];
		if (state_q == ST_AWAIT && div_rsp.done)
			a_val_q <= ip_val[15:0];
		if (state_q == ST_FWAIT && div_rsp.done)
			f_val_q <= ip_val;
		if (state_q == ST_SINE && sin_step_q == 3'd1)
			x2_q <= prod_q[61:30];
		if (state_q == ST_SINE && sin_step_q == 3'd7)
			wave_q <= sin_u[31] ? -$signed(w_cap) : $signed(w_cap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			playing_q    <= 1'b0;
			amp_seg_q    <= '0;
			freq_seg_q   <= '0;
			amp_el_q     <= '0;
			freq_el_q    <= '0;
			phase_q      <= '0;
			amp_used_q   <= SEGW'(1);
			freq_used_q  <= SEGW'(1);
			wave_sel_q   <= erov_pkg::WAVE_SINE;
			lfsr_q       <= erov_pkg::LfsrSeed;
			sin_step_q   <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_active_q <= 1'b0;
			out_fin_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_ch.opcode)
							erov_pkg::OP_START: begin
								amp_used_q  <= (int'(in_ch.amp_count) > SEGMENT_DEPTH) ?
									SEGW'(SEGMENT_DEPTH) : SEGW'(in_ch.amp_count);
								freq_used_q <= (int'(in_ch.freq_count) > SEGMENT_DEPTH) ?
									SEGW'(SEGMENT_DEPTH) : SEGW'(in_ch.freq_count);
								wave_sel_q  <= in_ch.waveform;
								amp_seg_q   <= '0;
								freq_seg_q  <= '0;
								amp_el_q    <= '0;
								freq_el_q   <= '0;
								phase_q     <= '0;
								playing_q   <= 1'b1;
								out_valid_q  <= 1'b1;
								out_sample_q <= '0;
								out_active_q <= 1'b1;
								out_fin_q    <= 1'b0;
							end
							erov_pkg::OP_TICK: begin
								if (playing_q) begin
									state_q <= ST_READ;
								end else begin
									out_valid_q  <= 1'b1;
									out_sample_q <= in_ch.mix_in;
									out_active_q <= 1'b0;
									out_fin_q    <= 1'b0;
								end
							end
							default: begin
								out_valid_q  <= 1'b1;
								out_sample_q <= '0;
								out_active_q <= playing_q;
								out_fin_q    <= 1'b0;
							end
						endcase
					end
				end
				ST_READ:  state_q <= ST_AMUL;
				ST_AMUL:  state_q <= (a_dur_q == '0) ? ST_FMUL : ST_ADIV;
				ST_ADIV:  state_q <= ST_AWAIT;
				ST_AWAIT: if (div_rsp.done) state_q <= ST_FMUL;
				ST_FMUL: begin
					if (f_dur_q != '0)
						state_q <= ST_FDIV;
					else
						state_q <= (wave_sel_q == erov_pkg::WAVE_SINE) ? ST_SINE : ST_VMUL;
					sin_step_q <= '0;
				end
				ST_FDIV:  state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (div_rsp.done)
						state_q <= (wave_sel_q == erov_pkg::WAVE_SINE) ? ST_SINE : ST_VMUL;
				end
				ST_SINE: begin
					sin_step_q <= sin_step_q + 3'd1;
					if (sin_step_q == 3'd7)
						state_q <= ST_VMUL;
				end
				ST_VMUL:  state_q <= ST_FIN;
				ST_FIN: begin
					state_q      <= ST_IDLE;
					out_valid_q  <= 1'b1;
					out_sample_q <= mix_sat;
					out_active_q <= !(a_over || f_over);
					out_fin_q    <= a_over || f_over;
					if (a_over || f_over)
						playing_q <= 1'b0;
					if (wave_sel_q == erov_pkg::WAVE_NOISE)
						lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ erov_pkg::LfsrTaps) : (lfsr_q >> 1);
					phase_q  <= phase_sum[PHASE_BITS-1:0];
					amp_el_q <= (a_done && !a_over) ? 20'd0 : a_el_inc;
					if (a_done)
						amp_seg_q <= a_seg_inc[SEGW-1:0];
					// pitch envelope holds on the tick that ends the amplitude table
					if (!a_over) begin
						freq_el_q <= (f_done && !f_over) ? 20'd0 : f_el_inc;
						if (f_done)
							freq_seg_q <= f_seg_inc[SEGW-1:0];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.sample_out     = out_sample_q;
	assign out_ch.voice_active   = out_active_q;
	assign out_ch.voice_finished = out_fin_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q || state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("input taken while a word is in flight");
	a_finish_ends_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fin_q) |-> (!out_active_q && !playing_q))
		else $error("finished word with voice still active");
	a_segment_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (int'(amp_seg_q) < SEGMENT_DEPTH && int'(freq_seg_q) < SEGMENT_DEPTH))
		else $error("segment index past table while playing");
	a_div_only_ramps: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_den != '0))
		else $error("divider started on a held segment");
endmodule
